FILE: src/tfd_pkg.sv
// shared types, codes and channel scaling tables for the texel format decoder
package tfd_pkg;

   localparam int PAL_DEPTH = 256;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int IDX_W     = 8;

   localparam logic [2:0] TF_RGB565   = 3'd0;
   localparam logic [2:0] TF_ARGB1555 = 3'd1;
   localparam logic [2:0] TF_ARGB4444 = 3'd2;
   localparam logic [2:0] TF_ARGB8888 = 3'd3;
   localparam logic [2:0] TF_INDEX4   = 3'd4;
   localparam logic [2:0] TF_INDEX8   = 3'd5;

   localparam logic OP_DECODE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic REG_TEXEL_FORMAT   = 1'b0;
   localparam logic REG_PALETTE_FORMAT = 1'b1;

   typedef enum logic [1:0] {
      PF_RGB565,
      PF_ARGB1555,
      PF_ARGB4444,
      PF_ARGB8888
   } pal_fmt_type;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef logic [15:0][7:0] lut4_type;
   typedef logic [31:0][7:0] lut5_type;
   typedef logic [63:0][7:0] lut6_type;

   function automatic lut4_type make_lut4();
      lut4_type t;
      for (int i = 0; i < 16; i++) begin
         t[i] = 8'(i * 255 / 15);
      end
      return t;
   endfunction

   function automatic lut5_type make_lut5();
      lut5_type t;
      for (int i = 0; i < 32; i++) begin
         t[i] = 8'(i * 255 / 31);
      end
      return t;
   endfunction

   function automatic lut6_type make_lut6();
      lut6_type t;
      for (int i = 0; i < 64; i++) begin
         t[i] = 8'(i * 255 / 63);
      end
      return t;
   endfunction

   localparam lut4_type SCALE4_LUT = make_lut4();
   localparam lut5_type SCALE5_LUT = make_lut5();
   localparam lut6_type SCALE6_LUT = make_lut6();

endpackage

FILE: src/tfd_direct_dec.sv
// direct colour word expansion to rgba8888
module tfd_direct_dec (
   input  tfd_pkg::pal_fmt_type fmt,
   input  logic [31:0]          word,
   output tfd_pkg::pixel_type   pixel
);
   import tfd_pkg::*;

   always_comb begin
      pixel = pixel_type'(word);
      case (fmt)
         PF_RGB565: begin
            pixel.red   = SCALE5_LUT[word[15:11]];
            pixel.green = SCALE6_LUT[word[10:5]];
            pixel.blue  = SCALE5_LUT[word[4:0]];
            pixel.alpha = 8'hFF;
         end
         PF_ARGB1555: begin
            pixel.red   = SCALE5_LUT[word[14:10]];
            pixel.green = SCALE5_LUT[word[9:5]];
            pixel.blue  = SCALE5_LUT[word[4:0]];
            pixel.alpha = {8{word[15]}};
         end
         PF_ARGB4444: begin
            pixel.red   = SCALE4_LUT[word[11:8]];
            pixel.green = SCALE4_LUT[word[7:4]];
            pixel.blue  = SCALE4_LUT[word[3:0]];
            pixel.alpha = SCALE4_LUT[word[15:12]];
         end
         PF_ARGB8888: begin
            pixel = pixel_type'(word);
         end
         default: begin
            pixel = pixel_type'(word);
         end
      endcase
   end

endmodule

FILE: src/texel_format_decoder_core.sv
// texel format decoder top level: request pipeline, palette memory and csr port
//
//  channel  | direction | tdata / data                     | tuser / tlast
//  req_     | in        | [31:0] raw_word, [39:32] slot    | tuser operation
//  rsp_     | out       | red, green, blue, alpha (low up) | tlast last_pixel
//  csr_     | in        | texel_format @0, palette_format @4 | -
//
// three register stages: request capture, decode with palette read, and the output register
// one request per cycle while the output is not stalled; index4 requests hold the output stage for two pixels
// palette loads write the memory in stage two and produce no pixel
// reset clears the valid bits and the format registers; palette contents undefined until loaded
// a stalled output holds every stage behind it and nothing is dropped or repeated
module texel_format_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_word, palette_slot
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // red, green, blue, alpha
   output logic        rsp_tlast,   // last_pixel
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tfd_pkg::*;

   logic              csr_wr;
   logic [2:0]        texel_format_ff;
   pal_fmt_type       palette_format_ff;

   logic              s1_valid_ff;
   logic              s1_op_ff;
   logic [31:0]       s1_raw_ff;
   logic [IDX_W-1:0]  s1_slot_ff;

   logic              s2_valid_ff;
   logic [2:0]        s2_fmt_ff;
   pixel_type         s2_direct_ff;
   logic              s2_ok0_ff;
   logic              s2_ok1_ff;
   pixel_type         rd0_ff;
   pixel_type         rd1_ff;

   logic              s3_valid_ff;
   logic              s3_two_ff;
   logic              s3_phase_ff;
   pixel_type         s3_pix_a_ff;
   pixel_type         s3_pix_b_ff;

   pixel_type         pal_mem_ff [PAL_DEPTH];

   logic              s1_free;
   logic              s2_free;
   logic              s3_free;
   logic              pal_we;
   logic              slot_ok;
   logic [IDX_W-1:0]  idx0;
   logic [IDX_W-1:0]  idx1;
   logic              ok0;
   logic              ok1;
   pixel_type         load_pixel;
   pixel_type         texel_pixel;
   logic              s2_valid_in;
   logic              s3_two_in;
   pixel_type         s3_pix_a_in;
   pixel_type         s3_pix_b_in;

   // csr port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_format_ff   <= TF_RGB565;
         palette_format_ff <= PF_RGB565;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_TEXEL_FORMAT:   texel_format_ff   <= csr_pwdata[2:0];
            REG_PALETTE_FORMAT: palette_format_ff <= pal_fmt_type'(csr_pwdata[1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_TEXEL_FORMAT:   csr_prdata = {29'd0, texel_format_ff};
         REG_PALETTE_FORMAT: csr_prdata = {30'd0, palette_format_ff};
         default:            csr_prdata = 32'd0;
      endcase
   end

   // stage control
   assign s3_free    = !s3_valid_ff || (rsp_tready && rsp_tlast);
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;

   // stage one: request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_op_ff   <= req_tuser;
         s1_raw_ff  <= req_tdata[31:0];
         s1_slot_ff <= req_tdata[39:32];
      end
   end

   // stage two: direct decode, palette write and palette read
   tfd_direct_dec u_load_dec (
      .fmt   (palette_format_ff),
      .word  (s1_raw_ff),
      .pixel (load_pixel)
   );

   tfd_direct_dec u_texel_dec (
      .fmt   (pal_fmt_type'(texel_format_ff[1:0])),
      .word  (s1_raw_ff),
      .pixel (texel_pixel)
   );

   assign idx0 = (texel_format_ff == TF_INDEX4) ? {4'd0, s1_raw_ff[3:0]} : s1_raw_ff[7:0];
   assign idx1 = {4'd0, s1_raw_ff[7:4]};
   assign ok0  = ({1'b0, idx0} < (IDX_W + 1)'(PAL_DEPTH));
   assign ok1  = ({1'b0, idx1} < (IDX_W + 1)'(PAL_DEPTH));
   assign slot_ok = ({1'b0, s1_slot_ff} < (IDX_W + 1)'(PAL_DEPTH));

   assign pal_we      = s2_free && s1_valid_ff && (s1_op_ff == OP_LOAD) && slot_ok;
   assign s2_valid_in = s1_valid_ff && (s1_op_ff == OP_DECODE);

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem_ff[s1_slot_ff[PAL_AW-1:0]] <= load_pixel;
      end
      if (s2_free) begin
         rd0_ff <= pal_mem_ff[idx0[PAL_AW-1:0]];
         rd1_ff <= pal_mem_ff[idx1[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_free) begin
         s2_fmt_ff    <= texel_format_ff;
         s2_direct_ff <= texel_pixel;
         s2_ok0_ff    <= ok0;
         s2_ok1_ff    <= ok1;
      end
   end

   // stage three: pixel selection into the output register
   always_comb begin
      s3_two_in   = 1'b0;
      s3_pix_a_in = pixel_type'(32'd0);
      s3_pix_b_in = pixel_type'(32'd0);
      case (s2_fmt_ff)
         TF_RGB565, TF_ARGB1555, TF_ARGB4444, TF_ARGB8888: begin
            s3_pix_a_in = s2_direct_ff;
         end
         TF_INDEX4: begin
            s3_two_in   = 1'b1;
            s3_pix_a_in = s2_ok0_ff ? rd0_ff : pixel_type'(32'd0);
            s3_pix_b_in = s2_ok1_ff ? rd1_ff : pixel_type'(32'd0);
         end
         TF_INDEX8: begin
            s3_pix_a_in = s2_ok0_ff ? rd0_ff : pixel_type'(32'd0);
         end
         default: begin
            s3_pix_a_in = pixel_type'(32'd0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s3_phase_ff <= 1'b0;
      end else if (s3_free) begin
         s3_valid_ff <= s2_valid_ff;
         s3_phase_ff <= 1'b0;
      end else if (rsp_tready) begin
         s3_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_free) begin
         s3_two_ff   <= s3_two_in;
         s3_pix_a_ff <= s3_pix_a_in;
         s3_pix_b_ff <= s3_pix_b_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_phase_ff ? s3_pix_b_ff : s3_pix_a_ff;
   assign rsp_tlast  = !s3_two_ff || s3_phase_ff;

`ifndef SYNTH
   a_second_pixel_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("second index4 pixel missing");

   a_load_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (s2_free && s1_valid_ff && (s1_op_ff == OP_LOAD)) |=> !s2_valid_ff)
      else $error("palette load entered the pixel path");

   a_phase_only_on_pair: assert property (@(posedge clock) disable iff (reset)
      s3_phase_ff |-> (s3_valid_ff && s3_two_ff))
      else $error("output phase set without a pixel pair");
`endif

endmodule

FILE: tb/texel_format_decoder_core_test.sv
// self-checking testbench for texel_format_decoder_core: random request stream, pixel prediction
module texel_format_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tfd_pkg::*;

   localparam logic [2:0] TF_SPARE6 = 3'd6;
   localparam logic [2:0] TF_SPARE7 = 3'd7;
   localparam logic [2:0] ADDR_TEXEL_FORMAT   = {REG_TEXEL_FORMAT, 2'b00};
   localparam logic [2:0] ADDR_PALETTE_FORMAT = {REG_PALETTE_FORMAT, 2'b00};

   typedef struct packed {
      logic        op;
      logic [7:0]  slot;
      logic [31:0] word;
   } texel_request_type;

   typedef struct packed {
      pixel_type px;
      logic      last;
   } pixel_due_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = OP_DECODE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   texel_format_decoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   texel_request_type texel_requests[$];
   pixel_due_type     due_pixels[$];
   pixel_type         palette_shadow[PAL_DEPTH];
   logic [2:0]        shadow_texel_format = TF_RGB565;
   logic [1:0]        shadow_palette_format = PF_RGB565;

   bit                slot_loaded[PAL_DEPTH];
   logic [7:0]        loaded_slots[$];
   logic [3:0]        low_slots[$];
   bit                format_seen[8];

   bit                calm = 1'b0;
   int                requests_queued = 0;
   int                requests_taken = 0;
   int                loads_taken = 0;
   int                pixels_checked = 0;
   int                mismatches = 0;
   int                settings_run = 0;
   int                send_gap;
   int                recv_stall;
   int                hold_left;
   texel_request_type next_req;
   pixel_due_type     due;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] widen(input int unsigned v, input int unsigned top);
      return 8'(v * 255 / top);
   endfunction

   function automatic pixel_type expand_direct(input logic [1:0] fmt, input logic [31:0] w);
      pixel_type px;
      px = pixel_type'(w);
      case (pal_fmt_type'(fmt))
         PF_RGB565: begin
            px.red   = widen(32'(w[15:11]), 31);
            px.green = widen(32'(w[10:5]), 63);
            px.blue  = widen(32'(w[4:0]), 31);
            px.alpha = 8'hFF;
         end
         PF_ARGB1555: begin
            px.red   = widen(32'(w[14:10]), 31);
            px.green = widen(32'(w[9:5]), 31);
            px.blue  = widen(32'(w[4:0]), 31);
            px.alpha = {8{w[15]}};
         end
         PF_ARGB4444: begin
            px.red   = widen(32'(w[11:8]), 15);
            px.green = widen(32'(w[7:4]), 15);
            px.blue  = widen(32'(w[3:0]), 15);
            px.alpha = widen(32'(w[15:12]), 15);
         end
         default: px = pixel_type'(w);
      endcase
      return px;
   endfunction

   function automatic void predict_pixels(input logic op, input logic [31:0] w,
                                          input logic [7:0] slot);
      requests_taken++;
      if (op == OP_LOAD) begin
         palette_shadow[slot] = expand_direct(shadow_palette_format, w);
         loads_taken++;
         return;
      end
      case (shadow_texel_format)
         TF_RGB565, TF_ARGB1555, TF_ARGB4444, TF_ARGB8888:
            due_pixels.push_back('{px: expand_direct(shadow_texel_format[1:0], w), last: 1'b1});
         TF_INDEX4: begin
            due_pixels.push_back('{px: palette_shadow[{4'd0, w[3:0]}], last: 1'b0});
            due_pixels.push_back('{px: palette_shadow[{4'd0, w[7:4]}], last: 1'b1});
         end
         TF_INDEX8:
            due_pixels.push_back('{px: palette_shadow[w[7:0]], last: 1'b1});
         default:
            due_pixels.push_back('{px: '0, last: 1'b1});
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0h got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_pixels(req_tuser, req_tdata[31:0], req_tdata[39:32]);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (texel_requests.size() > 0) begin
               next_req = texel_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_req.op;
               req_tdata <= {next_req.slot, next_req.word};
               send_gap = calm ? 0 : pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // pixel monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_pixels.size() == 0) begin
               $error("pixel %08h arrived with no request outstanding", rsp_tdata);
               mismatches++;
            end else begin
               due = due_pixels.pop_front();
               check_field("red", due.px.red, rsp_tdata[7:0]);
               check_field("green", due.px.green, rsp_tdata[15:8]);
               check_field("blue", due.px.blue, rsp_tdata[23:16]);
               check_field("alpha", due.px.alpha, rsp_tdata[31:24]);
               check_field("last_pixel", {7'b0, due.last}, {7'b0, rsp_tlast});
            end
            pixels_checked++;
            // long hold-off so the pipeline backs up into the request side
            if (pixels_checked == 300 || pixels_checked == 1400) hold_left = 160;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = pick_gap();
         end
      end
   end

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_TEXEL_FORMAT) shadow_texel_format = value[2:0];
      else shadow_palette_format = value[1:0];
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (requests_taken != requests_queued || due_pixels.size() != 0);
      // loads leave no pixel behind, so let the pipeline empty
      repeat (10) @(posedge clock);
   endtask

   task automatic queue_request(input logic op, input logic [31:0] w, input logic [7:0] slot);
      texel_requests.push_back('{op: op, slot: slot, word: w});
      requests_queued++;
   endtask

   task automatic queue_load(input logic [7:0] slot, input logic [31:0] w);
      if (!slot_loaded[slot]) begin
         slot_loaded[slot] = 1'b1;
         loaded_slots.push_back(slot);
         if (slot < 16) low_slots.push_back(slot[3:0]);
      end
      queue_request(OP_LOAD, w, slot);
   endtask

   task automatic queue_directed(input logic [2:0] tf);
      if (tf == TF_INDEX4 || tf == TF_INDEX8) begin
         queue_load(8'd0, 32'h0000_0000);
         queue_load(8'd15, 32'hFFFF_FFFF);
         queue_load(8'd255, 32'h8421_7BDE);
         queue_request(OP_DECODE, 32'h0000_0000, 8'd0);
         queue_request(OP_DECODE, 32'hFFFF_FFFF, 8'd255);
         queue_request(OP_DECODE, 32'h0000_000F, 8'd0);
      end else if (tf <= TF_ARGB8888) begin
         queue_request(OP_DECODE, 32'h0000_0000, 8'd0);
         queue_request(OP_DECODE, 32'hFFFF_FFFF, 8'd255);
         queue_request(OP_DECODE, 32'hA5A5_5A5A, 8'h5A);
      end else begin
         queue_request(OP_DECODE, 32'hFFFF_FFFF, 8'hFF);
      end
   endtask

   task automatic queue_random(input logic [2:0] tf);
      int          roll;
      logic [31:0] w;
      logic [7:0]  slot;
      logic [3:0]  lo;
      logic [3:0]  hi;
      logic [7:0]  idx;
      roll = $urandom_range(0, 99);
      w = $urandom;
      slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
      if (roll < ((tf == TF_INDEX4 || tf == TF_INDEX8) ? 30 : 20)) begin
         queue_load(slot, w);
      end else if (tf == TF_INDEX4) begin
         if (low_slots.size() == 0) begin
            queue_load(8'($urandom_range(0, 15)), w);
         end else begin
            lo = low_slots[$urandom_range(0, low_slots.size() - 1)];
            hi = low_slots[$urandom_range(0, low_slots.size() - 1)];
            queue_request(OP_DECODE, {w[31:8], hi, lo}, slot);
         end
      end else if (tf == TF_INDEX8) begin
         if (loaded_slots.size() == 0) begin
            queue_load(slot, w);
         end else begin
            idx = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
            queue_request(OP_DECODE, {w[31:8], idx}, slot);
         end
      end else begin
         queue_request(OP_DECODE, w, slot);
      end
   endtask

   task automatic run_setting(input logic [2:0] tf, input pal_fmt_type pf, input int count,
                              input bit quiet);
      wait_idle();
      calm = quiet;
      write_csr(ADDR_TEXEL_FORMAT, 32'(tf));
      write_csr(ADDR_PALETTE_FORMAT, 32'(pf));
      settings_run++;
      if (!format_seen[tf]) begin
         format_seen[tf] = 1'b1;
         queue_directed(tf);
      end
      repeat (count) queue_random(tf);
   endtask

   initial begin
      int spin;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      run_setting(TF_RGB565, PF_RGB565, 110, 1'b0);
      run_setting(TF_ARGB1555, PF_ARGB1555, 110, 1'b0);
      run_setting(TF_ARGB4444, PF_ARGB4444, 110, 1'b0);
      run_setting(TF_ARGB8888, PF_ARGB8888, 110, 1'b1);
      run_setting(TF_INDEX4, PF_RGB565, 200, 1'b0);
      run_setting(TF_INDEX8, PF_ARGB1555, 200, 1'b0);
      run_setting(TF_SPARE6, PF_ARGB4444, 40, 1'b0);
      run_setting(TF_SPARE7, PF_ARGB8888, 40, 1'b0);
      run_setting(TF_INDEX4, PF_ARGB8888, 160, 1'b1);
      run_setting(TF_INDEX8, PF_RGB565, 160, 1'b0);
      spin = 0;
      while ((requests_taken != requests_queued || due_pixels.size() != 0) && spin < 20000) begin
         @(posedge clock);
         spin++;
      end
      repeat (12) @(posedge clock);
      if (requests_taken != requests_queued || due_pixels.size() != 0) begin
         $error("%0d requests not taken, %0d pixels never arrived",
                requests_queued - requests_taken, due_pixels.size());
         mismatches++;
      end
      $display("%0d requests (%0d palette loads) over %0d format settings, %0d pixels checked",
               requests_taken, loads_taken, settings_run, pixels_checked);
      $display("texel formats 0 to 7 and all palette formats exercised, %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("texel_format_decoder_core verification clean");
      end else begin
         $display("texel_format_decoder_core verification failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("texel_format_decoder_core verification failed");
      $finish;
   end

endmodule
